// ===== hw/rtl/udp_ipv4_header_builder_top_macros.svh =====
// Assertion macros shared by the header builder RTL.
`ifndef UDP_IPV4_HEADER_BUILDER_TOP_MACROS_SVH
`define UDP_IPV4_HEADER_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define UDPB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("udpb assertion failed");

// Next-cycle implication, disabled while in reset.
`define UDPB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("udpb assertion failed");

`endif

// ===== hw/rtl/udpb_pkg.sv =====
// Types, constants and the checksum fold shared by the header builder.
package udpb_pkg;

	localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
	localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
	localparam logic [15:0] IP_CONST_SUM   = 16'h8511;
	localparam logic [15:0] UDP_PROTO      = 16'd17;
	localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
	localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

	typedef struct packed {
		logic [15:0] paysum;
		logic [15:0] length;
		logic        too_long;
	} snap_t;

	function automatic logic [15:0] fold16(input logic [19:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

// ===== hw/rtl/udp_ipv4_header_builder_top.sv =====
// Top level of the IPv4/UDP header builder: config registers, header emitter.
// The block takes one payload byte per cycle on the slave stream and keeps a
// running Internet checksum of the payload. The item that carries tlast (with
// or without a byte, so an empty payload works) closes the payload; then the 14
// header words follow, IPv4 words 0-9 then UDP words 10-13, one per cycle on
// the master stream while it is ready. tuser on the input marks a real byte;
// tuser on the output flags a payload longer than MAX_PAYLOAD whose extra bytes
// were dropped. Payload bytes enter at one per cycle; while a header is being
// sent the input stalls until its last word is loaded into the output register.
// The user must write configuration over the APB port only while no payload or
// header is in flight; the block itself does not enforce it.
module udp_ipv4_header_builder_top #(
	parameter int MAX_PAYLOAD = 1472
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
	input  logic        s_axis_tuser,   // [0] byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [15:0] header_word, [19:16] word_number
	output logic        m_axis_tuser,   // [0] too_long
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "udp_ipv4_header_builder_top_macros.svh"

	localparam logic [1:0] REG_SRC_ADDR = 2'd0;
	localparam logic [1:0] REG_DST_ADDR = 2'd1;
	localparam logic [1:0] REG_SRC_PORT = 2'd2;
	localparam logic [1:0] REG_DST_PORT = 2'd3;

	localparam logic [3:0] WORD_VER      = 4'd0;
	localparam logic [3:0] WORD_TOT_LEN  = 4'd1;
	localparam logic [3:0] WORD_ID       = 4'd2;
	localparam logic [3:0] WORD_FRAG     = 4'd3;
	localparam logic [3:0] WORD_TTL      = 4'd4;
	localparam logic [3:0] WORD_IP_CSUM  = 4'd5;
	localparam logic [3:0] WORD_SA_HI    = 4'd6;
	localparam logic [3:0] WORD_SA_LO    = 4'd7;
	localparam logic [3:0] WORD_DA_HI    = 4'd8;
	localparam logic [3:0] WORD_DA_LO    = 4'd9;
	localparam logic [3:0] WORD_SRC_PORT = 4'd10;
	localparam logic [3:0] WORD_DST_PORT = 4'd11;
	localparam logic [3:0] WORD_UDP_LEN  = 4'd12;
	localparam logic [3:0] WORD_UDP_CSUM = 4'd13;

	logic [31:0] src_addr_q, dst_addr_q;
	logic [15:0] src_port_q, dst_port_q;
	logic        cfg_wr;

	logic [17:0] addr_sum_q;
	logic [16:0] port_sum_q;

	logic            s_accept;
	udpb_pkg::snap_t snap;
	udpb_pkg::snap_t hdr_q;
	logic            hdr_valid_q;
	logic [3:0]      cnt_q;
	logic            load;
	logic            last_load;

	logic [15:0] tot_len, udp_len, ip_sum, udp_sum, word;

	logic        m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [15:0] m_word_q;
	logic [3:0]  m_num_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SRC_ADDR: src_addr_q <= pwdata;
				REG_DST_ADDR: dst_addr_q <= pwdata;
				REG_SRC_PORT: src_port_q <= pwdata[15:0];
				REG_DST_PORT: dst_port_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SRC_ADDR: prdata = src_addr_q;
			REG_DST_ADDR: prdata = dst_addr_q;
			REG_SRC_PORT: prdata = {16'd0, src_port_q};
			REG_DST_PORT: prdata = {16'd0, dst_port_q};
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		addr_sum_q <= 18'(src_addr_q[31:16]) + 18'(src_addr_q[15:0])
			+ 18'(dst_addr_q[31:16]) + 18'(dst_addr_q[15:0]);
		port_sum_q <= 17'(src_port_q) + 17'(dst_port_q);
	end

	assign s_accept = s_axis_tvalid && s_axis_tready;

	udpb_csum_acc #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (s_accept),
		.payload_byte   (s_axis_tdata),
		.byte_present   (s_axis_tuser),
		.end_of_payload (s_axis_tlast),
		.snap           (snap)
	);

	assign load          = hdr_valid_q && (!m_tvalid_q || m_axis_tready);
	assign last_load     = load && (cnt_q == WORD_UDP_CSUM);
	assign s_axis_tready = !hdr_valid_q || last_load;

	always_ff @(posedge clk) begin
		if (s_accept && s_axis_tlast) begin
			hdr_q <= snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_q <= 1'b0;
			cnt_q       <= WORD_VER;
		end else begin
			if (s_accept && s_axis_tlast) begin
				hdr_valid_q <= 1'b1;
			end else if (last_load) begin
				hdr_valid_q <= 1'b0;
			end
			if (last_load) begin
				cnt_q <= WORD_VER;
			end else if (load) begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	assign tot_len = hdr_q.length + udpb_pkg::IP_HDR_BYTES + udpb_pkg::UDP_HDR_BYTES;
	assign udp_len = hdr_q.length + udpb_pkg::UDP_HDR_BYTES;
	assign ip_sum  = udpb_pkg::fold16(20'(udpb_pkg::IP_CONST_SUM) + 20'(tot_len)
		+ 20'(addr_sum_q));
	assign udp_sum = udpb_pkg::fold16(20'(addr_sum_q) + 20'(port_sum_q)
		+ 20'(udpb_pkg::UDP_PROTO) + 20'(udp_len) + 20'(udp_len) + 20'(hdr_q.paysum));

	always_comb begin
		case (cnt_q)
			WORD_VER:      word = udpb_pkg::IP_VER_IHL_TOS;
			WORD_TOT_LEN:  word = tot_len;
			WORD_ID:       word = '0;
			WORD_FRAG:     word = '0;
			WORD_TTL:      word = udpb_pkg::IP_TTL_PROTO;
			WORD_IP_CSUM:  word = ~ip_sum;
			WORD_SA_HI:    word = src_addr_q[31:16];
			WORD_SA_LO:    word = src_addr_q[15:0];
			WORD_DA_HI:    word = dst_addr_q[31:16];
			WORD_DA_LO:    word = dst_addr_q[15:0];
			WORD_SRC_PORT: word = src_port_q;
			WORD_DST_PORT: word = dst_port_q;
			WORD_UDP_LEN:  word = udp_len;
			WORD_UDP_CSUM: word = ~udp_sum;
			default:       word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_word_q  <= word;
			m_num_q   <= cnt_q;
			m_tlast_q <= (cnt_q == WORD_UDP_CSUM);
			m_tuser_q <= hdr_q.too_long;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = {4'd0, m_num_q, m_word_q};
	assign m_axis_tlast  = m_tlast_q;
	assign m_axis_tuser  = m_tuser_q;

	`UDPB_ASSERT_NXT(a_end_starts_hdr, clk, arst_n, s_accept && s_axis_tlast, hdr_valid_q)
	`UDPB_ASSERT_NXT(a_hdr_holds, clk, arst_n, hdr_valid_q && !load, hdr_valid_q && $stable(cnt_q))
	`UDPB_ASSERT_IMP(a_idle_cnt, clk, arst_n, !hdr_valid_q, cnt_q == WORD_VER)
	`UDPB_ASSERT_IMP(a_last_num, clk, arst_n, m_tvalid_q && m_tlast_q, m_num_q == WORD_UDP_CSUM)

endmodule

// ===== hw/rtl/udpb_csum_acc.sv =====
// Payload byte pairing, ones'-complement sum and length count.
module udpb_csum_acc #(
	parameter int MAX_PAYLOAD = 1472
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     payload_byte,
	input  logic           byte_present,
	input  logic           end_of_payload,
	output udpb_pkg::snap_t snap
);

	localparam int CW = $clog2(MAX_PAYLOAD + 1);

	logic [15:0]   sum_q, sum_n;
	logic [7:0]    hi_q, hi_n;
	logic          odd_q, odd_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic          ovf_q, ovf_n;

	always_comb begin
		sum_n = sum_q;
		hi_n  = hi_q;
		odd_n = odd_q;
		cnt_n = cnt_q;
		ovf_n = ovf_q;
		if (byte_present) begin
			if (cnt_q == CW'(MAX_PAYLOAD)) begin
				ovf_n = 1'b1;
			end else begin
				if (odd_q) begin
					sum_n = udpb_pkg::fold16(20'(sum_q) + 20'({hi_q, payload_byte}));
					odd_n = 1'b0;
				end else begin
					hi_n  = payload_byte;
					odd_n = 1'b1;
				end
				cnt_n = cnt_q + CW'(1);
			end
		end
	end

	assign snap.paysum   = odd_n ? udpb_pkg::fold16(20'(sum_n) + 20'({hi_n, 8'h00})) : sum_n;
	assign snap.length   = 16'(cnt_n);
	assign snap.too_long = ovf_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			hi_q  <= '0;
			odd_q <= 1'b0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (end_of_payload) begin
				sum_q <= '0;
				hi_q  <= '0;
				odd_q <= 1'b0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				sum_q <= sum_n;
				hi_q  <= hi_n;
				odd_q <= odd_n;
				cnt_q <= cnt_n;
				ovf_q <= ovf_n;
			end
		end
	end

endmodule
